>>> sv/deq_pkg.sv
// shared types and codes for the double ended queue
package deq_pkg;

   // fixed field widths
   localparam int OPCODE_WIDTH = 3;
   localparam int ERROR_WIDTH  = 2;

   // operation codes carried by a request transaction
   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_NOP        = 3'd5
   } op_type;

   // error codes returned with every response transaction
   typedef enum logic [ERROR_WIDTH-1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic read;
   } dp_cmd_type;

endpackage

>>> sv/double_ended_queue.sv
// double ended queue top level: controller, datapath and checks
//
// A bounded deque of DEPTH entries of DATA_WIDTH bits in a circular buffer.
// Each request transaction carries an opcode (push back, push front, pop
// front, pop back, clear, no-op; codes 6 and 7 act as no-op) and a value
// used only by the pushes. Exactly one response transaction follows each
// request, giving the error code (pop from empty, push into full), the front
// and back values (zero when empty), an empty flag and the count after the
// operation. A failed pop or push leaves the contents unchanged. One
// transaction is in flight at a time: accept, the registered read of the
// slot memory, then the response. The two read ports of the slot memory
// set the read state. No clearing pass is needed after reset.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [OPCODE_WIDTH-1:0]     req_opcode,
   input  logic [DATA_WIDTH-1:0]       req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ERROR_WIDTH-1:0]      rsp_error,
   output logic [DATA_WIDTH-1:0]       rsp_front_value,
   output logic [DATA_WIDTH-1:0]       rsp_back_value,
   output logic                        rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]  rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   dp_cmd_type cmd;

   // handshake sequencing
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // pointers, count and slot memory
   deq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_error       (rsp_error),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_count       (rsp_count)
   );

   // only one transaction in flight
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   // response follows an accepted request after the memory read
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##2 rsp_valid)
      else $error("response not presented two cycles after accept");

   // count stays within the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= CW'(DEPTH)))
      else $error("count exceeds capacity");

   // a rejected push only happens on a full deque
   a_full_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error == ERR_FULL) |-> (rsp_count == CW'(DEPTH)))
      else $error("full error reported on a deque that is not full");

endmodule

>>> sv/deq_ram.sv
// generic single write port ram with two registered read ports
module deq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> sv/deq_ctrl.sv
// controller state machine for the double ended queue
module deq_ctrl
   import deq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake outputs
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.accept = 1'b0;
      cmd.read   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/deq_datapath.sv
// pointer, count and slot storage datapath of the double ended queue
module deq_datapath
   import deq_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   input  logic [OPCODE_WIDTH-1:0]      req_opcode,
   input  logic [DATA_WIDTH-1:0]        req_value,
   output logic [ERROR_WIDTH-1:0]       rsp_error,
   output logic [DATA_WIDTH-1:0]        rsp_front_value,
   output logic [DATA_WIDTH-1:0]        rsp_back_value,
   output logic                         rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   logic [AW-1:0]          head_ff;
   logic [AW-1:0]          head_in;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [ERROR_WIDTH-1:0] err_ff;
   logic [ERROR_WIDTH-1:0] err_in;

   logic                   full;
   logic                   empty;
   logic [AW-1:0]          head_dec;
   logic [AW-1:0]          head_inc;
   logic [SW-1:0]          tail_sum;
   logic [AW-1:0]          tail_idx;
   logic [SW-1:0]          back_sum;
   logic [AW-1:0]          back_idx;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DATA_WIDTH-1:0]  rd_front;
   logic [DATA_WIDTH-1:0]  rd_back;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // circular index arithmetic
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   assign tail_sum = {1'b0, head_ff} + SW'(count_ff);
   assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                              : AW'(tail_sum);

   // back slot sits one below the tail, head itself when empty
   always_comb begin
      back_sum = {1'b0, head_ff};
      if (!empty) begin
         back_sum = tail_sum - SW'(1);
      end
   end
   assign back_idx = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH))
                                              : AW'(back_sum);

   // operation decode
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      err_in   = ERR_OK;
      wr_en    = 1'b0;
      wr_addr  = tail_idx;
      unique case (req_opcode)
         OP_PUSH_BACK: begin
            if (full) begin
               err_in = ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_PUSH_FRONT: begin
            wr_addr = head_dec;
            if (full) begin
               err_in = ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               head_in  = head_dec;
               count_in = count_ff + CW'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               err_in = ERR_EMPTY;
            end else begin
               head_in  = head_inc;
               count_in = count_ff - CW'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               err_in = ERR_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         OP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
            head_in = head_ff;
         end
      endcase
   end

   // pointer and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // error code of the current transaction
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         err_ff <= err_in;
      end
   end

   // slot storage, written on an accepted push and read once per transaction
   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock     (clock),
      .wr_en     (cmd.accept & wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_en     (cmd.read),
      .rd_addr_a (head_ff),
      .rd_addr_b (back_idx),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   // response fields
   assign rsp_error       = err_ff;
   assign rsp_front_value = empty ? '0 : rd_front;
   assign rsp_back_value  = empty ? '0 : rd_back;
   assign rsp_is_empty    = empty;
   assign rsp_count       = count_ff;

endmodule

>>> tb/double_ended_queue_tb.sv
// self-checking testbench for the double ended queue
module double_ended_queue_tb;
   import deq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int DW          = 8;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int RANDOM_OPS  = 1250;
   localparam int IDLE_PCT    = 36;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 8;

   // opcodes outside the enum, handled as no-op by the block
   localparam logic [OPCODE_WIDTH-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_WIDTH-1:0] OP_SPARE_HI = 3'd7;

   // one response transaction as seen on the rsp_ ports
   typedef struct packed {
      err_type          error;
      logic [DW-1:0]    front;
      logic [DW-1:0]    back;
      logic             empty;
      logic [CNT_W-1:0] count;
   } deque_result_type;

   // directed stimulus row; pinned rows carry a hand-written response
   typedef struct {
      logic [OPCODE_WIDTH-1:0] op;
      logic [DW-1:0]           val;
      int                      reps;
      bit                      pinned;
      deque_result_type        want;
   } script_row_type;

   localparam int SCRIPT_ROWS = 17;

   script_row_type directed_script [SCRIPT_ROWS] = '{
      // empty deque: failed pop, clear, and every flavor of no-op
      '{OP_POP_FRONT,  8'h00, 1,  1'b1, '{ERR_EMPTY, 8'h00, 8'h00, 1'b1, 5'd0}},
      '{OP_CLEAR,      8'h00, 1,  1'b1, '{ERR_OK,    8'h00, 8'h00, 1'b1, 5'd0}},
      '{OP_NOP,        8'hFF, 1,  1'b1, '{ERR_OK,    8'h00, 8'h00, 1'b1, 5'd0}},
      '{OP_SPARE_LO,   8'h5A, 1,  1'b1, '{ERR_OK,    8'h00, 8'h00, 1'b1, 5'd0}},
      '{OP_SPARE_HI,   8'hA5, 1,  1'b1, '{ERR_OK,    8'h00, 8'h00, 1'b1, 5'd0}},
      // value extremes at both ends
      '{OP_PUSH_BACK,  8'hFF, 1,  1'b1, '{ERR_OK,    8'hFF, 8'hFF, 1'b0, 5'd1}},
      '{OP_PUSH_FRONT, 8'h00, 1,  1'b1, '{ERR_OK,    8'h00, 8'hFF, 1'b0, 5'd2}},
      // fill to capacity, then push into a full deque from both sides
      '{OP_PUSH_BACK,  8'h55, 13, 1'b0, '0},
      '{OP_PUSH_FRONT, 8'hAA, 1,  1'b0, '0},
      '{OP_PUSH_BACK,  8'h12, 1,  1'b1, '{ERR_FULL,  8'hAA, 8'h55, 1'b0, 5'd16}},
      '{OP_PUSH_FRONT, 8'h34, 1,  1'b1, '{ERR_FULL,  8'hAA, 8'h55, 1'b0, 5'd16}},
      // clear a full deque, then wrap the head below slot zero
      '{OP_CLEAR,      8'h00, 1,  1'b1, '{ERR_OK,    8'h00, 8'h00, 1'b1, 5'd0}},
      '{OP_PUSH_FRONT, 8'h01, 1,  1'b1, '{ERR_OK,    8'h01, 8'h01, 1'b0, 5'd1}},
      '{OP_PUSH_BACK,  8'h80, 1,  1'b0, '0},
      '{OP_POP_FRONT,  8'h00, 1,  1'b0, '0},
      '{OP_POP_BACK,   8'h00, 1,  1'b1, '{ERR_OK,    8'h00, 8'h00, 1'b1, 5'd0}},
      '{OP_POP_BACK,   8'h00, 1,  1'b1, '{ERR_EMPTY, 8'h00, 8'h00, 1'b1, 5'd0}}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [OPCODE_WIDTH-1:0] req_opcode = OP_NOP;
   logic [DW-1:0]           req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [ERROR_WIDTH-1:0]  rsp_error;
   logic [DW-1:0]           rsp_front_value;
   logic [DW-1:0]           rsp_back_value;
   logic                    rsp_is_empty;
   logic [CNT_W-1:0]        rsp_count;

   // side information that travels with the request; the block does not see it
   bit                      req_pinned = 1'b0;
   deque_result_type        req_pinned_want = '0;

   int                      idle_pct = IDLE_PCT;
   int                      mismatch_count = 0;
   int                      cycle_count = 0;
   deque_result_type        pending_results [$];

   // shadow copy of the deque contents
   logic [DW-1:0]           shadow_slots [DEPTH];
   logic [IDX_W-1:0]        shadow_head = '0;
   logic [CNT_W-1:0]        shadow_fill = '0;

   double_ended_queue #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(DW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_error(rsp_error),
      .rsp_front_value(rsp_front_value),
      .rsp_back_value(rsp_back_value),
      .rsp_is_empty(rsp_is_empty),
      .rsp_count(rsp_count)
   );

   // clock generation
   initial begin
      forever #1 clock = ~clock;
   end

   // apply one operation to the shadow deque and return the response it produces;
   // depth is a power of two, so index wrap is plain truncation
   function automatic deque_result_type apply_deque_op(input logic [OPCODE_WIDTH-1:0] op,
                                                       input logic [DW-1:0] val);
      deque_result_type r;
      r = '0;
      r.error = ERR_OK;
      case (op)
         OP_PUSH_BACK: begin
            if (shadow_fill == DEPTH) begin
               r.error = ERR_FULL;
            end else begin
               shadow_slots[IDX_W'(shadow_head + shadow_fill)] = val;
               shadow_fill++;
            end
         end
         OP_PUSH_FRONT: begin
            if (shadow_fill == DEPTH) begin
               r.error = ERR_FULL;
            end else begin
               shadow_head--;
               shadow_slots[shadow_head] = val;
               shadow_fill++;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_fill == 0) begin
               r.error = ERR_EMPTY;
            end else begin
               shadow_head++;
               shadow_fill--;
            end
         end
         OP_POP_BACK: begin
            if (shadow_fill == 0) begin
               r.error = ERR_EMPTY;
            end else begin
               shadow_fill--;
            end
         end
         OP_CLEAR: begin
            shadow_fill = '0;
            shadow_head = '0;
         end
         default: begin
         end
      endcase
      r.count = shadow_fill;
      r.empty = (shadow_fill == 0);
      if (!r.empty) begin
         r.front = shadow_slots[shadow_head];
         r.back  = shadow_slots[IDX_W'(shadow_head + shadow_fill - 1)];
      end
      return r;
   endfunction

   // one line per mismatch
   task automatic report_mismatch(input string msg);
      $display("[%0d] mismatch: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // present one request transaction, with random idle cycles ahead of it
   task automatic issue_request(input logic [OPCODE_WIDTH-1:0] op, input logic [DW-1:0] val,
                                input bit pinned, input deque_result_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_value       <= val;
      req_pinned      <= pinned;
      req_pinned_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // random operation: mode 0 leans to pushes, 1 to pops, 2 is balanced
   function automatic logic [OPCODE_WIDTH-1:0] pick_op(input int mode);
      int roll;
      int push_pct;
      roll = $urandom_range(99);
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      if (roll < 2) begin
         return OP_CLEAR;
      end
      if (roll < 6) begin
         case ($urandom_range(2))
            0: return OP_NOP;
            1: return OP_SPARE_LO;
            default: return OP_SPARE_HI;
         endcase
      end
      if ($urandom_range(99) < push_pct) begin
         return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end
      return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   // stimulus: reset, directed script, then random operations
   initial begin
      int mode;
      mode = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[r]) begin
         for (int k = 0; k < directed_script[r].reps; k++) begin
            issue_request(directed_script[r].op, directed_script[r].val,
                          directed_script[r].pinned, directed_script[r].want);
         end
      end

      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (i % 50 == 0) begin
            mode = $urandom_range(2);
         end
         // quiet stretch with no idling on either side
         idle_pct = (i >= 500 && i < 750) ? 0 : IDLE_PCT;
         issue_request(pick_op(mode), DW'($urandom_range(255)), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // let the monitor record the last request before waiting for the drain
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** double_ended_queue: PASSED **");
      end else begin
         $display("** double_ended_queue: FAILED **");
      end
      $finish;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // record expectations on request transactions, check response transactions
   always @(posedge clock) begin
      deque_result_type predicted;
      deque_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = apply_deque_op(req_opcode, req_value);
            pending_results.push_back(req_pinned ? req_pinned_want : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = pending_results.pop_front();
               if (rsp_error !== want.error)
                  report_mismatch($sformatf("error expected %0d got %0d",
                                            want.error, rsp_error));
               if (rsp_front_value !== want.front)
                  report_mismatch($sformatf("front expected %0h got %0h",
                                            want.front, rsp_front_value));
               if (rsp_back_value !== want.back)
                  report_mismatch($sformatf("back expected %0h got %0h",
                                            want.back, rsp_back_value));
               if (rsp_is_empty !== want.empty)
                  report_mismatch($sformatf("is_empty expected %0d got %0d",
                                            want.empty, rsp_is_empty));
               if (rsp_count !== want.count)
                  report_mismatch($sformatf("count expected %0d got %0d",
                                            want.count, rsp_count));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0d] timeout, %0d responses outstanding",
                  cycle_count, pending_results.size());
         $display("** double_ended_queue: FAILED **");
         $finish;
      end
   end

endmodule

>>> double_ended_queue.f
sv/deq_pkg.sv
sv/deq_ram.sv
sv/deq_ctrl.sv
sv/deq_datapath.sv
sv/double_ended_queue.sv
tb/double_ended_queue_tb.sv
